// ===== sv/hbk_pkg.sv =====
// ----------------------------------------------------------------------------
// hbk_pkg
// Types, code tables and lookup functions of the boot keyboard translator.
// ----------------------------------------------------------------------------
`default_nettype none

package hbk_pkg;

   localparam logic [7:0] SHIFT_MASK = 8'h22;
   localparam logic [7:0] CTRL_MASK  = 8'h11;
   localparam logic [7:0] MOD_BASE   = 8'hE0;
   localparam logic [7:0] USE_CAPS   = 8'h39;
   localparam logic [7:0] USE_ERROR  = 8'h01;
   localparam logic [7:0] USE_RIGHT  = 8'h4F;
   localparam logic [7:0] USE_LEFT   = 8'h50;
   localparam logic [7:0] USE_DOWN   = 8'h51;
   localparam logic [7:0] USE_UP     = 8'h52;
   localparam logic [7:0] USE_HOME   = 8'h4A;
   localparam logic [7:0] USE_END    = 8'h4D;
   localparam logic [7:0] USE_PGUP   = 8'h4B;
   localparam logic [7:0] USE_PGDN   = 8'h4E;
   localparam logic [7:0] USE_DEL    = 8'h4C;
   localparam logic [7:0] USE_BSLASH = 8'h64;
   localparam logic [7:0] CHR_ESC    = 8'h1B;
   localparam logic [7:0] CHR_BRACK  = 8'h5B;
   localparam logic [7:0] CHR_TILDE  = 8'h7E;
   localparam int         MAX_RESULTS = 44;

   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_CHAR = 1'b1;

   localparam logic CMD_REPORT = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic CSR_DELAY    = 1'b0;
   localparam logic CSR_INTERVAL = 1'b1;

   localparam logic [6:0] SCAN_ROM [0:82] = '{
      7'h00,7'h00,7'h00,7'h00,
      7'h1E,7'h30,7'h2E,7'h20,7'h12,7'h21,7'h22,7'h23,
      7'h17,7'h24,7'h25,7'h26,7'h32,7'h31,7'h18,7'h19,
      7'h10,7'h13,7'h1F,7'h14,7'h16,7'h2F,7'h11,7'h2D,
      7'h15,7'h2C,7'h02,7'h03,7'h04,7'h05,7'h06,7'h07,
      7'h08,7'h09,7'h0A,7'h0B,7'h1C,7'h01,7'h0E,7'h0F,
      7'h39,7'h0C,7'h0D,7'h1A,7'h1B,7'h2B,7'h00,7'h27,
      7'h28,7'h29,7'h33,7'h34,7'h35,7'h3A,7'h3B,7'h3C,
      7'h3D,7'h3E,7'h3F,7'h40,7'h41,7'h42,7'h43,7'h44,
      7'h57,7'h58,7'h00,7'h00,7'h00,7'h52,7'h47,7'h49,
      7'h53,7'h4F,7'h51,7'h4D,7'h4B,7'h50,7'h48
   };

   localparam logic [6:0] EXT_ROM [0:7] = '{
      7'h1D,7'h2A,7'h38,7'h5B,7'h1D,7'h36,7'h38,7'h5C
   };

   localparam logic [7:0] LOWER_ROM [0:26] = '{
      8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,
      8'h0A,8'h1B,8'h08,8'h09,8'h20,8'h2D,8'h3D,8'h5B,8'h5D,8'h5C,
      8'h00,8'h3B,8'h27,8'h60,8'h2C,8'h2E,8'h2F
   };

   localparam logic [7:0] UPPER_ROM [0:26] = '{
      8'h21,8'h40,8'h23,8'h24,8'h25,8'h5E,8'h26,8'h2A,8'h28,8'h29,
      8'h0A,8'h1B,8'h08,8'h09,8'h20,8'h5F,8'h2B,8'h7B,8'h7D,8'h7C,
      8'h00,8'h3A,8'h22,8'h7E,8'h3C,8'h3E,8'h3F
   };

   typedef struct packed {
      logic       ok;
      logic       ext;
      logic [6:0] code;
   } scan_type;

   typedef struct packed {
      logic [2:0]      n;
      logic [3:0][7:0] c;
   } chars_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] scan_code;
      logic       extended;
      logic       pressed;
      logic [7:0] char_code;
      logic       last_result;
   } res_type;

   function automatic scan_type scan_lookup(input logic [7:0] usage);
      scan_type r;
      r = '0;
      if (usage inside {[8'hE0:8'hE7]}) begin
         r.ok = 1'b1;
         r.ext = 1'b1;
         r.code = EXT_ROM[usage[2:0]];
      end else if (usage < 8'h53 && SCAN_ROM[usage[6:0]] != 7'h00) begin
         r.ok = 1'b1;
         r.code = SCAN_ROM[usage[6:0]];
      end
      return r;
   endfunction

   function automatic chars_type char_lookup(input logic [7:0] usage,
                                             input logic [7:0] mods,
                                             input logic caps);
      chars_type  r;
      logic       shift;
      logic       ctrl;
      logic       letter;
      logic       up;
      logic [7:0] c;
      logic [7:0] ofs;
      shift = |(mods & SHIFT_MASK);
      ctrl = |(mods & CTRL_MASK);
      letter = usage inside {[8'h04:8'h1D]};
      up = letter ? (shift ^ caps) : shift;
      ofs = usage - 8'h1E;
      c = 8'h00;
      r.n = 3'd0;
      r.c[0] = CHR_ESC;
      r.c[1] = CHR_BRACK;
      r.c[2] = 8'h00;
      r.c[3] = 8'h00;
      case (usage)
         USE_RIGHT: begin r.c[2] = 8'h43; r.n = 3'd3; end
         USE_LEFT: begin r.c[2] = 8'h44; r.n = 3'd3; end
         USE_DOWN: begin r.c[2] = 8'h42; r.n = 3'd3; end
         USE_UP: begin r.c[2] = 8'h41; r.n = 3'd3; end
         USE_HOME: begin r.c[2] = 8'h48; r.n = 3'd3; end
         USE_END: begin r.c[2] = 8'h46; r.n = 3'd3; end
         USE_PGUP: begin r.c[2] = 8'h35; r.c[3] = CHR_TILDE; r.n = 3'd4; end
         USE_PGDN: begin r.c[2] = 8'h36; r.c[3] = CHR_TILDE; r.n = 3'd4; end
         USE_DEL: begin r.c[2] = 8'h33; r.c[3] = CHR_TILDE; r.n = 3'd4; end
         default: begin
            if (usage == USE_BSLASH) begin
               c = up ? 8'h7C : 8'h5C;
            end else if (letter) begin
               c = (up ? 8'h41 : 8'h61) + (usage - 8'h04);
            end else if (usage inside {[8'h1E:8'h38]}) begin
               c = up ? UPPER_ROM[ofs[4:0]] : LOWER_ROM[ofs[4:0]];
            end
            if (c != 8'h00) begin
               if (ctrl && letter) begin
                  c = usage - 8'h03;
               end
               r.c[0] = c;
               r.n = 3'd1;
            end
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/hbk_if.sv =====
// ----------------------------------------------------------------------------
// hbk_if
// Channel interfaces of the boot keyboard translator.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbk_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [47:0] time_now;
   logic [7:0]  modifier_byte;
   logic [7:0]  key_0;
   logic [7:0]  key_1;
   logic [7:0]  key_2;
   logic [7:0]  key_3;
   logic [7:0]  key_4;
   logic [7:0]  key_5;
   modport source(output valid, cmd, time_now, modifier_byte, key_0, key_1, key_2,
                  key_3, key_4, key_5, input ready);
   modport sink(input valid, cmd, time_now, modifier_byte, key_0, key_1, key_2,
                key_3, key_4, key_5, output ready);
endinterface

interface hbk_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [6:0] scan_code;
   logic       extended;
   logic       pressed;
   logic [7:0] char_code;
   logic       last_result;
   modport source(output valid, kind, scan_code, extended, pressed, char_code,
                  last_result, input ready);
   modport sink(input valid, kind, scan_code, extended, pressed, char_code,
                last_result, output ready);
endinterface

interface hbk_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [23:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/hbk_lane.sv =====
// ----------------------------------------------------------------------------
// hbk_lane
// Compares one key usage against a list of usages and flags a match.
// ----------------------------------------------------------------------------
`default_nettype none

module hbk_lane #(
   parameter int N = 6
) (
   input  wire logic [7:0]     usage,
   input  wire logic [N*8-1:0] list,
   output logic                hit
);

   always_comb begin
      hit = 1'b0;
      for (int j = 0; j < N; j++) begin
         if (list[j*8 +: 8] == usage) begin
            hit = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/hid_boot_keyboard_translator.sv =====
// ----------------------------------------------------------------------------
// hid_boot_keyboard_translator
// Turns boot keyboard reports into key events and terminal characters and
// repeats the characters of held keys on repeat ticks.
//
//   Channel  Dir  Carries
//   req_if   in   report or repeat tick with timestamp
//   rsp_if   out  key event or character, last_result on final one
//   csr_if   in   repeat_delay / repeat_interval writes
//
// A report steps through the modifier bits, the key slots with new keys and
// their characters, a step that frees held entries of released keys and the
// previous key slots; a tick steps through the held entries and the characters
// of due ones. Both end in a final step. Compare lanes check all slots at once.
// Reset is synchronous and clears the previous report and held-key usages but
// not the held-key times. Output stalls hold the sequencer; a new item is taken
// once the previous one is done.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_boot_keyboard_translator import hbk_pkg::*; #(
   parameter int REPORT_KEYS  = 6,
   parameter int HELD_ENTRIES = 6
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hbk_req_if.sink    req_if,
   hbk_rsp_if.source  rsp_if,
   hbk_csr_if.sink    csr_if
);

   localparam int KEY_W  = (REPORT_KEYS > 1) ? $clog2(REPORT_KEYS) : 1;
   localparam int HELD_W = (HELD_ENTRIES > 1) ? $clog2(HELD_ENTRIES) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MOD  = 3'd1;
   localparam logic [2:0] S_KEY  = 3'd2;
   localparam logic [2:0] S_FREE = 3'd3;
   localparam logic [2:0] S_REL  = 3'd4;
   localparam logic [2:0] S_TICK = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic [2:0]  sub_ff, sub_in;
   logic [5:0]  count_ff;
   logic        cmd_ff;
   logic [47:0] now_ff;
   logic [7:0]  mods_ff;
   logic [7:0]  keys_ff [REPORT_KEYS];
   logic [7:0]  prev_keys_ff [REPORT_KEYS];
   logic [7:0]  prev_mods_ff;
   logic [7:0]  held_usage_ff [HELD_ENTRIES];
   logic [47:0] held_time_ff [HELD_ENTRIES];
   logic        caps_ff;
   logic [23:0] delay_ff;
   logic [23:0] interval_ff;
   res_type     pend_ff;
   logic        pend_valid_ff;
   res_type     out_ff, out_in;
   logic        out_valid_ff;

   logic [7:0]  req_keys [6];
   logic [REPORT_KEYS*8-1:0]  keys_flat;
   logic [REPORT_KEYS*8-1:0]  prev_flat;
   logic [REPORT_KEYS-1:0]    hit_prev;
   logic [REPORT_KEYS-1:0]    hit_rel;
   logic [HELD_ENTRIES-1:0]   hit_held;

   logic [KEY_W-1:0]  ki;
   logic [HELD_W-1:0] hi;
   logic [7:0]        cur_usage;
   logic [7:0]        cur_mods;
   scan_type          sc;
   chars_type         ch;
   logic              free_found;
   logic [HELD_W-1:0] free_idx;
   logic [47:0]       sched_a;
   logic [47:0]       sched_b;
   logic [47:0]       sched_time;
   logic [6:0]        need;

   logic        accept;
   logic        out_free;
   logic        gen_ok;
   logic        gen_fire;
   logic        move;
   logic        gen_valid;
   res_type     gen_res;
   logic        caps_toggle;
   logic        ins_en;
   logic        sched_en;
   logic        free_en;
   logic        key_last;
   logic        held_last;

   assign req_keys[0] = req_if.key_0;
   assign req_keys[1] = req_if.key_1;
   assign req_keys[2] = req_if.key_2;
   assign req_keys[3] = req_if.key_3;
   assign req_keys[4] = req_if.key_4;
   assign req_keys[5] = req_if.key_5;

   always_comb begin
      for (int i = 0; i < REPORT_KEYS; i++) begin
         keys_flat[i*8 +: 8] = keys_ff[i];
         prev_flat[i*8 +: 8] = prev_keys_ff[i];
      end
   end

   for (genvar i = 0; i < REPORT_KEYS; i++) begin : g_key_lane
      hbk_lane #(.N(REPORT_KEYS)) u_new (
         .usage(keys_ff[i]), .list(prev_flat), .hit(hit_prev[i]));
      hbk_lane #(.N(REPORT_KEYS)) u_rel (
         .usage(prev_keys_ff[i]), .list(keys_flat), .hit(hit_rel[i]));
   end

   for (genvar k = 0; k < HELD_ENTRIES; k++) begin : g_held_lane
      hbk_lane #(.N(REPORT_KEYS)) u_held (
         .usage(held_usage_ff[k]), .list(keys_flat), .hit(hit_held[k]));
   end

   assign ki = idx_ff[KEY_W-1:0];
   assign hi = idx_ff[HELD_W-1:0];
   assign key_last = (idx_ff == 4'(REPORT_KEYS - 1));
   assign held_last = (idx_ff == 4'(HELD_ENTRIES - 1));

   always_comb begin
      case (state_ff)
         S_KEY: cur_usage = keys_ff[ki];
         S_REL: cur_usage = prev_keys_ff[ki];
         S_TICK: cur_usage = held_usage_ff[hi];
         S_MOD: cur_usage = MOD_BASE + {5'd0, idx_ff[2:0]};
         default: cur_usage = 8'h00;
      endcase
      cur_mods = (state_ff == S_TICK) ? prev_mods_ff : mods_ff;
   end

   assign sc = scan_lookup(cur_usage);
   assign ch = char_lookup(cur_usage, cur_mods, caps_ff);
   assign need = 7'(count_ff) + 7'(ch.n);

   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int k = HELD_ENTRIES - 1; k >= 0; k--) begin
         if (held_usage_ff[k] == 8'h00) begin
            free_found = 1'b1;
            free_idx = HELD_W'(k);
         end
      end
   end

   assign sched_a = held_time_ff[hi] + {24'd0, interval_ff};
   assign sched_b = now_ff + {24'd0, interval_ff};
   assign sched_time = (sched_a < now_ff) ? sched_b : sched_a;

   assign accept = req_if.valid && req_if.ready;
   assign out_free = !out_valid_ff || rsp_if.ready;
   assign gen_ok = !pend_valid_ff || out_free;
   assign gen_fire = gen_valid && gen_ok;
   assign move = pend_valid_ff && out_free && (gen_fire || state_ff == S_FIN);

   always_comb begin
      out_in = pend_ff;
      out_in.last_result = (state_ff == S_FIN);
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      sub_in = sub_ff;
      gen_valid = 1'b0;
      gen_res = '0;
      caps_toggle = 1'b0;
      ins_en = 1'b0;
      sched_en = 1'b0;
      free_en = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_if.cmd == CMD_TICK) ? S_TICK : S_MOD;
               idx_in = '0;
               sub_in = '0;
            end
         end
         S_MOD: begin
            if (mods_ff[idx_ff[2:0]] != prev_mods_ff[idx_ff[2:0]]) begin
               gen_valid = 1'b1;
               gen_res.kind = KIND_KEY;
               gen_res.scan_code = sc.code;
               gen_res.extended = sc.ext;
               gen_res.pressed = mods_ff[idx_ff[2:0]];
            end
            if (!gen_valid || gen_ok) begin
               if (idx_ff == 4'd7) begin
                  state_in = S_KEY;
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         S_KEY: begin
            if (sub_ff == 3'd0) begin
               if (cur_usage == 8'h00 || cur_usage == USE_ERROR || hit_prev[ki]) begin
                  if (key_last) begin
                     state_in = S_FREE;
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end else begin
                  gen_valid = sc.ok;
                  gen_res.kind = KIND_KEY;
                  gen_res.scan_code = sc.code;
                  gen_res.extended = sc.ext;
                  gen_res.pressed = 1'b1;
                  if (!gen_valid || gen_ok) begin
                     sub_in = 3'd1;
                  end
               end
            end else if (sub_ff - 3'd1 < ch.n) begin
               gen_valid = 1'b1;
               gen_res.kind = KIND_CHAR;
               gen_res.char_code = ch.c[2'(sub_ff - 3'd1)];
               if (gen_ok) begin
                  sub_in = sub_ff + 3'd1;
               end
            end else begin
               caps_toggle = (cur_usage == USE_CAPS);
               ins_en = free_found;
               sub_in = '0;
               if (key_last) begin
                  state_in = S_FREE;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         S_FREE: begin
            free_en = 1'b1;
            state_in = S_REL;
            idx_in = '0;
         end
         S_REL: begin
            if (cur_usage != 8'h00 && cur_usage != USE_ERROR && !hit_rel[ki]) begin
               gen_valid = sc.ok;
               gen_res.kind = KIND_KEY;
               gen_res.scan_code = sc.code;
               gen_res.extended = sc.ext;
               gen_res.pressed = 1'b0;
            end
            if (!gen_valid || gen_ok) begin
               if (key_last) begin
                  state_in = S_FIN;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         S_TICK: begin
            if (sub_ff == 3'd0) begin
               if (cur_usage != 8'h00 && now_ff >= held_time_ff[hi]
                   && need <= 7'(MAX_RESULTS)) begin
                  sub_in = 3'd1;
               end else if (held_last) begin
                  state_in = S_FIN;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end else if (sub_ff - 3'd1 < ch.n) begin
               gen_valid = 1'b1;
               gen_res.kind = KIND_CHAR;
               gen_res.char_code = ch.c[2'(sub_ff - 3'd1)];
               if (gen_ok) begin
                  sub_in = sub_ff + 3'd1;
               end
            end else begin
               caps_toggle = (cur_usage == USE_CAPS);
               sched_en = 1'b1;
               sub_in = '0;
               if (held_last) begin
                  state_in = S_FIN;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         S_FIN: begin
            if (!pend_valid_ff || move) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         sub_ff <= '0;
         count_ff <= '0;
         caps_ff <= 1'b0;
         prev_mods_ff <= '0;
         delay_ff <= 24'd500000;
         interval_ff <= 24'd33000;
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < REPORT_KEYS; i++) begin
            prev_keys_ff[i] <= '0;
         end
         for (int k = 0; k < HELD_ENTRIES; k++) begin
            held_usage_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         sub_ff <= sub_in;
         if (csr_if.valid) begin
            if (csr_if.index == CSR_DELAY) begin
               delay_ff <= csr_if.data;
            end else begin
               interval_ff <= csr_if.data;
            end
         end
         if (accept) begin
            count_ff <= '0;
         end else if (gen_fire) begin
            count_ff <= count_ff + 6'd1;
         end
         if (caps_toggle) begin
            caps_ff <= !caps_ff;
         end
         if (ins_en) begin
            held_usage_ff[free_idx] <= cur_usage;
         end
         if (free_en) begin
            for (int k = 0; k < HELD_ENTRIES; k++) begin
               if (!hit_held[k]) begin
                  held_usage_ff[k] <= '0;
               end
            end
         end
         if (state_ff == S_FIN && cmd_ff == CMD_REPORT) begin
            prev_mods_ff <= mods_ff;
            for (int i = 0; i < REPORT_KEYS; i++) begin
               prev_keys_ff[i] <= keys_ff[i];
            end
         end
         if (gen_fire) begin
            pend_valid_ff <= 1'b1;
         end else if (move) begin
            pend_valid_ff <= 1'b0;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_if.cmd;
         now_ff <= req_if.time_now;
         mods_ff <= req_if.modifier_byte;
         for (int i = 0; i < REPORT_KEYS; i++) begin
            keys_ff[i] <= req_keys[i];
         end
      end
      if (ins_en) begin
         held_time_ff[free_idx] <= now_ff + {24'd0, delay_ff};
      end
      if (sched_en) begin
         held_time_ff[hi] <= sched_time;
      end
      if (gen_fire) begin
         pend_ff <= gen_res;
      end
      if (move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.kind = out_ff.kind;
   assign rsp_if.scan_code = out_ff.scan_code;
   assign rsp_if.extended = out_ff.extended;
   assign rsp_if.pressed = out_ff.pressed;
   assign rsp_if.char_code = out_ff.char_code;
   assign rsp_if.last_result = out_ff.last_result;

endmodule

`default_nettype wire

// ===== tb/sv/tb_hid_boot_keyboard_translator.sv =====
// ----------------------------------------------------------------------------
// tb_hid_boot_keyboard_translator
// Self-checking testbench of the boot keyboard translator. A scoreboard class
// predicts the key events and characters of every accepted report or repeat
// tick and checks each result in order. Directed reports and ticks cover the
// special keys, then random reports (some with random key bytes) and ticks run
// under several repeat settings, with random idling on both channels in all but the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hid_boot_keyboard_translator import hbk_pkg::*;;

   typedef logic [7:0] keys_type [6];

   class keyboard_scoreboard;
      logic [23:0] rep_delay;
      logic [23:0] rep_interval;
      logic [7:0]  last_mods;
      keys_type    last_keys;
      logic [7:0]  held_use [6];
      logic [47:0] held_due [6];
      logic        caps;
      res_type     pending [$];
      res_type     fresh [$];
      int          errors;
      int          matched;

      function new();
         rep_delay = 24'd500000;
         rep_interval = 24'd33000;
         last_mods = 8'h00;
         caps = 1'b0;
         errors = 0;
         matched = 0;
         for (int i = 0; i < 6; i++) begin
            last_keys[i] = 8'h00;
            held_use[i] = 8'h00;
            held_due[i] = 48'h0;
         end
      endfunction

      function void add(logic kind, logic [6:0] sc, logic ext, logic pr, logic [7:0] ch);
         res_type r;
         if (fresh.size() >= MAX_RESULTS) return;
         r.kind = kind;
         r.scan_code = sc;
         r.extended = ext;
         r.pressed = pr;
         r.char_code = ch;
         r.last_result = 1'b0;
         fresh.push_back(r);
      endfunction

      function void key_out(logic [7:0] u, logic pr);
         if (u >= MOD_BASE && u <= 8'hE7)
            add(KIND_KEY, EXT_ROM[u[2:0]], 1'b1, pr, 8'h00);
         else if (u < 8'h53 && SCAN_ROM[u[6:0]] != 7'h00)
            add(KIND_KEY, SCAN_ROM[u[6:0]], 1'b0, pr, 8'h00);
      endfunction

      function int term_chars(logic [7:0] u, logic [7:0] mods, output logic [7:0] b [4]);
         logic       shift;
         logic       ctrl;
         logic       letter;
         logic       up;
         logic [7:0] c;
         shift = (mods & SHIFT_MASK) != 0;
         ctrl = (mods & CTRL_MASK) != 0;
         letter = u >= 8'h04 && u <= 8'h1D;
         b[0] = CHR_ESC;
         b[1] = CHR_BRACK;
         b[2] = 8'h00;
         b[3] = CHR_TILDE;
         case (u)
            USE_RIGHT: begin b[2] = "C"; return 3; end
            USE_LEFT: begin b[2] = "D"; return 3; end
            USE_DOWN: begin b[2] = "B"; return 3; end
            USE_UP: begin b[2] = "A"; return 3; end
            USE_HOME: begin b[2] = "H"; return 3; end
            USE_END: begin b[2] = "F"; return 3; end
            USE_PGUP: begin b[2] = "5"; return 4; end
            USE_PGDN: begin b[2] = "6"; return 4; end
            USE_DEL: begin b[2] = "3"; return 4; end
            default: ;
         endcase
         up = letter ? (shift ^ caps) : shift;
         if (u == USE_BSLASH) c = up ? "|" : "\\";
         else if (letter) c = (up ? 8'h41 : 8'h61) + (u - 8'h04);
         else if (u >= 8'h1E && u <= 8'h38)
            c = up ? UPPER_ROM[u - 8'h1E] : LOWER_ROM[u - 8'h1E];
         else c = 8'h00;
         if (c == 8'h00) return 0;
         if (ctrl && letter) c = u - 8'h03;
         b[0] = c;
         return 1;
      endfunction

      function void type_chars(logic [7:0] u, logic [7:0] mods);
         logic [7:0] b [4];
         int         n;
         if (u == USE_CAPS) begin
            caps = !caps;
            return;
         end
         n = term_chars(u, mods, b);
         for (int i = 0; i < n; i++) add(KIND_CHAR, 7'h00, 1'b0, 1'b0, b[i]);
      endfunction

      function bit listed(keys_type l, logic [7:0] u);
         foreach (l[i]) if (l[i] == u) return 1;
         return 0;
      endfunction

      function void note_item(logic cmd, logic [47:0] now, logic [7:0] mods, keys_type keys);
         logic [7:0]  b [4];
         logic [47:0] target;
         fresh.delete();
         if (cmd == CMD_REPORT) begin
            for (int i = 0; i < 8; i++)
               if (mods[i] != last_mods[i]) key_out(8'(MOD_BASE + i), mods[i]);
            for (int i = 0; i < 6; i++) begin
               if (keys[i] == 8'h00 || keys[i] == USE_ERROR || listed(last_keys, keys[i]))
                  continue;
               key_out(keys[i], 1'b1);
               type_chars(keys[i], mods);
               for (int k = 0; k < 6; k++) begin
                  if (held_use[k] == 8'h00) begin
                     held_use[k] = keys[i];
                     held_due[k] = now + 48'(rep_delay);
                     break;
                  end
               end
            end
            for (int k = 0; k < 6; k++)
               if (held_use[k] != 8'h00 && !listed(keys, held_use[k])) held_use[k] = 8'h00;
            for (int i = 0; i < 6; i++) begin
               if (last_keys[i] == 8'h00 || last_keys[i] == USE_ERROR) continue;
               if (!listed(keys, last_keys[i])) key_out(last_keys[i], 1'b0);
            end
            last_keys = keys;
            last_mods = mods;
         end else begin
            for (int k = 0; k < 6; k++) begin
               if (held_use[k] == 8'h00 || now < held_due[k]) continue;
               if (term_chars(held_use[k], last_mods, b) > MAX_RESULTS - fresh.size())
                  continue;
               type_chars(held_use[k], last_mods);
               target = held_due[k] + 48'(rep_interval);
               if (target < now) target = now + 48'(rep_interval);
               held_due[k] = target;
            end
         end
         if (fresh.size() > 0) fresh[fresh.size() - 1].last_result = 1'b1;
         foreach (fresh[i]) pending.push_back(fresh[i]);
      endfunction

      function void check_result(res_type got);
         res_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result kind=%0d scan=%h ext=%0d pr=%0d char=%h last=%0d",
                     $time, got.kind, got.scan_code, got.extended, got.pressed,
                     got.char_code, got.last_result);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch expected kind=%0d scan=%h ext=%0d pr=%0d char=%h last=%0d, actual kind=%0d scan=%h ext=%0d pr=%0d char=%h last=%0d",
                     $time, want.kind, want.scan_code, want.extended, want.pressed,
                     want.char_code, want.last_result, got.kind, got.scan_code,
                     got.extended, got.pressed, got.char_code, got.last_result);
            errors++;
         end else begin
            matched++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   hbk_req_if req_if();
   hbk_rsp_if rsp_if();
   hbk_csr_if csr_if();

   hid_boot_keyboard_translator dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   keyboard_scoreboard board = new();
   bit          idle_on = 1'b1;
   int          sent_items = 0;
   int          stall_left = 0;
   logic [47:0] tnow;
   keys_type    cur_keys;
   logic [7:0]  cur_mods;

   initial forever #2 clock = ~clock;

   initial begin
      #20ms;
      $display("hid_boot_keyboard_translator test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (idle_on && stall_left == 0 && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 17);
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= (stall_left == 1);
      end else begin
         rsp_if.ready <= 1'b1;
      end
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_result('{rsp_if.kind, rsp_if.scan_code, rsp_if.extended,
                              rsp_if.pressed, rsp_if.char_code, rsp_if.last_result});
   end

   task automatic send_item(logic cmd, logic [47:0] t, logic [7:0] mods, keys_type keys);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_if.cmd <= cmd;
      req_if.time_now <= t;
      req_if.modifier_byte <= mods;
      req_if.key_0 <= keys[0];
      req_if.key_1 <= keys[1];
      req_if.key_2 <= keys[2];
      req_if.key_3 <= keys[3];
      req_if.key_4 <= keys[4];
      req_if.key_5 <= keys[5];
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      board.note_item(cmd, t, mods, keys);
      sent_items++;
   endtask

   task automatic report(logic [7:0] mods, keys_type keys);
      tnow += 48'd1000;
      send_item(CMD_REPORT, tnow, mods, keys);
      cur_keys = keys;
      cur_mods = mods;
   endtask

   task automatic tick(logic [47:0] advance);
      keys_type junk;
      foreach (junk[i]) junk[i] = 8'($urandom);
      tnow += advance;
      send_item(CMD_TICK, tnow, 8'($urandom), junk);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [23:0] data);
      csr_if.index <= idx;
      csr_if.data <= data;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == CSR_DELAY) board.rep_delay = data;
      else board.rep_interval = data;
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_repeat(logic [23:0] d, logic [23:0] i);
      drain();
      csr_write(CSR_DELAY, d);
      csr_write(CSR_INTERVAL, i);
   endtask

   function automatic logic [7:0] pick_usage();
      case ($urandom_range(0, 7))
         0: return 8'(MOD_BASE + $urandom_range(0, 7));
         1: return USE_CAPS;
         2: return 8'($urandom_range(USE_HOME, USE_UP));
         3: return 8'($urandom);
         default: return 8'($urandom_range(8'h04, 8'h38));
      endcase
   endfunction

   task automatic random_phase(int count, int unsigned step);
      keys_type k;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 2) == 0) begin
            tick(48'($urandom_range(0, step)));
         end else if ($urandom_range(0, 9) == 0) begin
            foreach (k[i]) k[i] = 8'($urandom);
            report(8'($urandom), k);
         end else begin
            k = cur_keys;
            foreach (k[i]) begin
               case ($urandom_range(0, 5))
                  3: k[i] = 8'h00;
                  4, 5: k[i] = pick_usage();
                  default: ;
               endcase
            end
            report($urandom_range(0, 1) ? cur_mods : cur_mods ^ 8'($urandom), k);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid <= 1'b0;
      req_if.cmd <= CMD_REPORT;
      req_if.time_now <= '0;
      req_if.modifier_byte <= '0;
      req_if.key_0 <= '0;
      req_if.key_1 <= '0;
      req_if.key_2 <= '0;
      req_if.key_3 <= '0;
      req_if.key_4 <= '0;
      req_if.key_5 <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_DELAY;
      csr_if.data <= '0;
      tnow = 48'd1000;
      cur_mods = 8'h00;
      foreach (cur_keys[i]) cur_keys[i] = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      report(8'hFF, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      report(8'h00, '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      report(8'h02, '{8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00});
      report(8'h01, '{8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      report(8'h00, '{USE_CAPS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      report(8'h00, '{8'h04, 8'h1E, 8'h2D, USE_BSLASH, 8'h00, 8'h00});
      report(8'h20, '{8'h04, 8'h1E, 8'h38, USE_BSLASH, 8'h00, 8'h00});
      report(8'h00, '{USE_CAPS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      report(8'h00, '{USE_RIGHT, USE_LEFT, USE_DOWN, USE_UP, USE_HOME, USE_END});
      report(8'h00, '{USE_PGUP, USE_PGDN, USE_DEL, 8'h32, USE_ERROR, 8'hFF});
      report(8'h00, '{8'hE0, 8'hE7, 8'h53, 8'h65, 8'h00, 8'h00});
      report(8'h00, '{8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04});
      report(8'h00, '{8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h05});
      tick(48'd600000);
      tick(48'd10);
      tick(48'd2000000);
      report(8'h10, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      report(8'h10, '{USE_CAPS, USE_PGUP, 8'h00, 8'h00, 8'h00, 8'h00});
      tick(48'd600000);
      tick(48'd33000);
      report(8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      tick(48'd1);

      random_phase(50, 80000);
      set_repeat(24'd0, 24'd1);
      random_phase(50, 4);
      set_repeat(24'hFFFFFF, 24'hFFFFFF);
      random_phase(45, 24'hFFFFFF);
      set_repeat(24'd100, 24'd0);
      tnow = 48'hFFFF_FFFF_F000;
      random_phase(45, 150);
      set_repeat(24'($urandom_range(0, 5000)), 24'($urandom_range(1, 3000)));
      random_phase(30, 4000);
      drain();
      idle_on = 1'b0;
      random_phase(68, 4000);

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d reports and ticks with %0d checked results under five repeat settings,",
               sent_items, board.matched);
      $display("including modifier, caps lock, escape-sequence, full-table and wrap cases.");
      if (board.errors == 0) begin
         $display("hid_boot_keyboard_translator test passed");
      end else begin
         $display("hid_boot_keyboard_translator test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/hbk_pkg.sv
sv/hbk_if.sv
sv/hbk_lane.sv
sv/hid_boot_keyboard_translator.sv
tb/sv/tb_hid_boot_keyboard_translator.sv
